// ===== hdl/wret_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted random eviction tree: shared definitions
// Field widths, operation and status codes, and defaults for the parameters.
// ----------------------------------------------------------------------------
package wret_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_KEY_BITS    = 64;

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 64;
    localparam int COST_W   = 24;
    localparam int SUM_W    = 40;
    localparam int RND_W    = 64;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    // Entry layout in memory, key in the top bits.
    localparam int CP_LSB      = 0;
    localparam int CC_LSB      = SUM_W;
    localparam int OP_LSB      = 2 * SUM_W;
    localparam int OC_LSB      = 2 * SUM_W + COST_W;
    localparam int KEY_LSB     = 2 * SUM_W + 2 * COST_W;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVICT  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDER    = 3'd4;

    localparam logic [SUM_W-1:0] LIMIT_RESET = 40'd80000000;

endpackage

// ===== hdl/wret_if.sv =====
// ----------------------------------------------------------------------------
// Weighted random eviction tree: channel interfaces
// Input item, result item and limit register write channels.
// ----------------------------------------------------------------------------
interface wret_in_if;
    logic                          valid;
    logic                          ready;
    logic [wret_pkg::FUNC_W-1:0]   func;
    logic [wret_pkg::KEY_W-1:0]    entry_key;
    logic [wret_pkg::COST_W-1:0]   entry_cost;
    logic [wret_pkg::COST_W-1:0]   entry_penalty_cost;
    logic [wret_pkg::RND_W-1:0]    random_value;

    modport source (output valid, func, entry_key, entry_cost, entry_penalty_cost,
                    random_value, input ready);
    modport sink (input valid, func, entry_key, entry_cost, entry_penalty_cost,
                  random_value, output ready);
endinterface

interface wret_out_if;
    logic                          valid;
    logic                          ready;
    logic [wret_pkg::STATUS_W-1:0] status;
    logic                          evicted;
    logic [wret_pkg::KEY_W-1:0]    evicted_key;
    logic [wret_pkg::SUM_W-1:0]    total_cost;
    logic [wret_pkg::SUM_W-1:0]    total_penalty_cost;
    logic [wret_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, status, evicted, evicted_key, total_cost,
                    total_penalty_cost, entry_count, input ready);
    modport sink (input valid, status, evicted, evicted_key, total_cost,
                  total_penalty_cost, entry_count, output ready);
endinterface

interface wret_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [wret_pkg::SUM_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== hdl/wret_mem.sv =====
// ----------------------------------------------------------------------------
// Weighted random eviction tree: entry memory
// Simple dual-port synchronous RAM, one write and one read a cycle,
// registered read data.
// ----------------------------------------------------------------------------
module wret_mem #(
    parameter int AW = 10,
    parameter int DW = 192
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // Read data holds until the next read.
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/wret_div.sv =====
// ----------------------------------------------------------------------------
// Weighted random eviction tree: modulo unit
// Restoring division, one dividend bit a cycle, remainder only.
// ----------------------------------------------------------------------------
module wret_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wret_pkg::RND_W-1:0] i_dividend,
    input  logic [wret_pkg::SUM_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [wret_pkg::SUM_W-1:0] o_rem
);
    import wret_pkg::*;

    localparam int CNT_W = $clog2(RND_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RND_W-1:0] r_dvd;
    logic [SUM_W-1:0] r_rem;
    logic [SUM_W-1:0] r_dsr;
    logic [SUM_W:0]   trial;

    assign trial = {r_rem, r_dvd[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so it fits.
                if (trial >= {1'b0, r_dsr}) begin
                    r_rem <= SUM_W'(trial - {1'b0, r_dsr});
                end else begin
                    r_rem <= trial[SUM_W-1:0];
                end
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== hdl/weighted_random_eviction_tree_unit.sv =====
// ----------------------------------------------------------------------------
// Weighted random eviction tree unit
// Keyed table in an implicit binary heap with subtree cost sums; weighted
// random eviction when the total penalty cost is over the limit.
// ----------------------------------------------------------------------------
// One item is handled at a time. Add or remove does a key scan of the table
// and then repairs the subtree sums up the tree for each change; evict runs
// the bit-serial modulo unit, walks down the tree and then does the removal.
// The single read and single write port of the entry memory set the pace of
// each of these steps. The next item is taken while the previous result
// waits in the output register.
module weighted_random_eviction_tree_unit #(
    parameter int MAX_ENTRIES = wret_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = wret_pkg::DEF_KEY_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wret_in_if.sink    i_in,
    wret_out_if.source o_out,
    wret_cfg_if.sink   i_cfg
);
    import wret_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = CW + 1;
    localparam int DW = KEY_LSB + KEY_BITS;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SCAN     = 5'd1;
    localparam logic [4:0] S_ADD_WR   = 5'd2;
    localparam logic [4:0] S_LIFT_RD  = 5'd3;
    localparam logic [4:0] S_LIFT_WR  = 5'd4;
    localparam logic [4:0] S_RDLAST   = 5'd5;
    localparam logic [4:0] S_GETLAST  = 5'd6;
    localparam logic [4:0] S_RDIDX    = 5'd7;
    localparam logic [4:0] S_WRIDX    = 5'd8;
    localparam logic [4:0] S_DIV      = 5'd9;
    localparam logic [4:0] S_W_CHK    = 5'd10;
    localparam logic [4:0] S_W_RDL    = 5'd11;
    localparam logic [4:0] S_W_DEC    = 5'd12;
    localparam logic [4:0] S_W_KEY    = 5'd13;
    localparam logic [4:0] S_W_KEYCAP = 5'd14;
    localparam logic [4:0] S_OUT      = 5'd15;

    logic [4:0]          r_state;
    logic [4:0]          r_ret;
    logic [FUNC_W-1:0]   r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [COST_W-1:0]   r_cost;
    logic [COST_W-1:0]   r_pen;
    logic [CW-1:0]       r_count;
    logic [SUM_W-1:0]    r_tot_cost;
    logic [SUM_W-1:0]    r_tot_pen;
    logic [SUM_W-1:0]    r_limit;
    logic [CW-1:0]       r_si;
    logic [CW-1:0]       r_ci;
    logic                r_pend;
    logic [NW-1:0]       r_node;
    logic [SUM_W-1:0]    r_dc;
    logic [SUM_W-1:0]    r_dp;
    logic [CW-1:0]       r_idx;
    logic [KEY_BITS-1:0] r_lkey;
    logic [COST_W-1:0]   r_lc;
    logic [COST_W-1:0]   r_lp;
    logic [SUM_W-1:0]    r_w;
    logic [COST_W-1:0]   r_own_p;
    logic [KEY_BITS-1:0] r_nkey;
    logic                r_lv;
    logic [KEY_BITS-1:0] r_ekey;
    logic                r_evicted;
    logic [STATUS_W-1:0] r_status;

    logic                r_ov;
    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_evicted;
    logic [KEY_W-1:0]    r_o_ekey;
    logic [SUM_W-1:0]    r_o_tc;
    logic [SUM_W-1:0]    r_o_tp;
    logic [COUNT_W-1:0]  r_o_count;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] rd;

    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_rem;

    logic [KEY_BITS-1:0] rd_key;
    logic [COST_W-1:0]   rd_oc;
    logic [COST_W-1:0]   rd_op;
    logic [SUM_W-1:0]    rd_cc;
    logic [SUM_W-1:0]    rd_cp;
    logic                match;
    logic                in_acc;
    logic                over;
    logic [NW-1:0]       parent;
    logic [NW:0]         lft;
    logic [SUM_W-1:0]    left_w;
    logic [SUM_W:0]      here_w;
    logic [CW-1:0]       last;

    assign rd_key = rd[KEY_LSB +: KEY_BITS];
    assign rd_oc  = rd[OC_LSB +: COST_W];
    assign rd_op  = rd[OP_LSB +: COST_W];
    assign rd_cc  = rd[CC_LSB +: SUM_W];
    assign rd_cp  = rd[CP_LSB +: SUM_W];

    assign match  = r_pend && (rd_key == r_key);
    assign in_acc = i_in.valid && i_in.ready;
    assign over   = (r_tot_pen > r_limit) && (r_count != '0);
    assign parent = (r_node - NW'(1)) >> 1;
    assign lft    = {r_node, 1'b1};
    assign left_w = r_lv ? SUM_W'(SUM_W'(rd_op) + rd_cp) : '0;
    assign here_w = (SUM_W + 1)'(left_w) + (SUM_W + 1)'(r_own_p);
    assign last   = r_count - CW'(1);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign div_start   = in_acc && (i_in.func == FUNC_EVICT) && over;

    // Every write is followed by a read only in a later cycle, so the
    // registered read always sees the updated entry.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (r_state)
            S_SCAN: begin
                mem_re    = !match && (r_si < r_count);
                mem_raddr = AW'(r_si);
            end
            S_ADD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_count);
                mem_wdata = {r_key, r_cost, r_pen, {SUM_W{1'b0}}, {SUM_W{1'b0}}};
            end
            S_LIFT_RD: begin
                mem_re    = (r_node != '0);
                mem_raddr = AW'(parent);
            end
            S_LIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_node);
                mem_wdata = {rd_key, rd_oc, rd_op, SUM_W'(rd_cc + r_dc),
                             SUM_W'(rd_cp + r_dp)};
            end
            S_RDLAST: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(last);
            end
            S_RDIDX, S_W_KEY: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_idx);
            end
            S_WRIDX: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx);
                mem_wdata = {r_lkey, r_lc, r_lp, rd_cc, rd_cp};
            end
            S_W_CHK: begin
                mem_re    = (r_node < NW'(r_count));
                mem_raddr = AW'(r_node);
            end
            S_W_RDL: begin
                mem_re    = (lft < (NW + 1)'(r_count));
                mem_raddr = AW'(lft);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_tot_cost <= '0;
            r_tot_pen  <= '0;
            r_limit    <= LIMIT_RESET;
            r_ov       <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
            if (r_ov && o_out.ready && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func    <= i_in.func;
                        r_key     <= i_in.entry_key[KEY_BITS-1:0];
                        r_cost    <= i_in.entry_cost;
                        r_pen     <= i_in.entry_penalty_cost;
                        r_evicted <= 1'b0;
                        r_ekey    <= '0;
                        r_si      <= '0;
                        r_pend    <= 1'b0;
                        case (i_in.func)
                            FUNC_ADD, FUNC_REMOVE: begin
                                r_status <= ST_DONE;
                                r_state  <= S_SCAN;
                            end
                            FUNC_EVICT: begin
                                if (over) begin
                                    r_status <= ST_DONE;
                                    r_state  <= S_DIV;
                                end else begin
                                    r_status <= ST_UNDER;
                                    r_state  <= S_OUT;
                                end
                            end
                            default: begin
                                r_status <= ST_DONE;
                                r_state  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_pend <= 1'b0;
                        r_idx  <= r_ci;
                        if (r_func == FUNC_ADD) begin
                            r_status <= ST_DUP;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_RDLAST;
                        end
                    end else if (r_si < r_count) begin
                        r_ci   <= r_si;
                        r_si   <= r_si + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (r_func != FUNC_ADD) begin
                            r_status <= ST_NOTFOUND;
                            r_state  <= S_OUT;
                        end else if (r_count == CW'(MAX_ENTRIES)) begin
                            r_status <= ST_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_ADD_WR;
                        end
                    end
                end
                S_ADD_WR: begin
                    r_node     <= NW'(r_count);
                    r_dc       <= SUM_W'(r_cost);
                    r_dp       <= SUM_W'(r_pen);
                    r_count    <= r_count + CW'(1);
                    r_tot_cost <= r_tot_cost + SUM_W'(r_cost);
                    r_tot_pen  <= r_tot_pen + SUM_W'(r_pen);
                    r_ret      <= S_OUT;
                    r_state    <= S_LIFT_RD;
                end
                S_LIFT_RD: begin
                    if (r_node == '0) begin
                        r_state <= r_ret;
                    end else begin
                        r_node  <= parent;
                        r_state <= S_LIFT_WR;
                    end
                end
                S_LIFT_WR: r_state <= S_LIFT_RD;
                S_RDLAST:  r_state <= S_GETLAST;
                S_GETLAST: begin
                    // Take the last entry out of the sums, then move it into
                    // the freed slot if that slot is not the last one.
                    r_lkey     <= rd_key;
                    r_lc       <= rd_oc;
                    r_lp       <= rd_op;
                    r_count    <= last;
                    r_tot_cost <= r_tot_cost - SUM_W'(rd_oc);
                    r_tot_pen  <= r_tot_pen - SUM_W'(rd_op);
                    r_node     <= NW'(last);
                    r_dc       <= SUM_W'(0) - SUM_W'(rd_oc);
                    r_dp       <= SUM_W'(0) - SUM_W'(rd_op);
                    r_ret      <= (r_idx < last) ? S_RDIDX : S_OUT;
                    r_state    <= S_LIFT_RD;
                end
                S_RDIDX: r_state <= S_WRIDX;
                S_WRIDX: begin
                    r_dc       <= SUM_W'(r_lc) - SUM_W'(rd_oc);
                    r_dp       <= SUM_W'(r_lp) - SUM_W'(rd_op);
                    r_tot_cost <= r_tot_cost + SUM_W'(r_lc) - SUM_W'(rd_oc);
                    r_tot_pen  <= r_tot_pen + SUM_W'(r_lp) - SUM_W'(rd_op);
                    r_node     <= NW'(r_idx);
                    r_ret      <= S_OUT;
                    r_state    <= S_LIFT_RD;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_w     <= div_rem;
                        r_node  <= '0;
                        r_state <= S_W_CHK;
                    end
                end
                S_W_CHK: begin
                    if (r_node < NW'(r_count)) begin
                        r_state <= S_W_RDL;
                    end else begin
                        r_idx   <= last;
                        r_state <= S_W_KEY;
                    end
                end
                S_W_RDL: begin
                    r_own_p <= rd_op;
                    r_nkey  <= rd_key;
                    r_lv    <= (lft < (NW + 1)'(r_count));
                    r_state <= S_W_DEC;
                end
                S_W_DEC: begin
                    if (r_w < left_w) begin
                        r_node  <= NW'(lft);
                        r_state <= S_W_CHK;
                    end else if ({1'b0, r_w} < here_w) begin
                        r_idx     <= CW'(r_node);
                        r_ekey    <= r_nkey;
                        r_evicted <= 1'b1;
                        r_state   <= S_RDLAST;
                    end else begin
                        r_w     <= SUM_W'({1'b0, r_w} - here_w);
                        r_node  <= NW'(lft + (NW + 1)'(1));
                        r_state <= S_W_CHK;
                    end
                end
                S_W_KEY: r_state <= S_W_KEYCAP;
                S_W_KEYCAP: begin
                    r_ekey    <= rd_key;
                    r_evicted <= 1'b1;
                    r_state   <= S_RDLAST;
                end
                S_OUT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov        <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_evicted <= r_evicted;
                        r_o_ekey    <= KEY_W'(r_ekey);
                        r_o_tc      <= r_tot_cost;
                        r_o_tp      <= r_tot_pen;
                        r_o_count   <= COUNT_W'(r_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid              = r_ov;
    assign o_out.status             = r_o_status;
    assign o_out.evicted            = r_o_evicted;
    assign o_out.evicted_key        = r_o_ekey;
    assign o_out.total_cost         = r_o_tc;
    assign o_out.total_penalty_cost = r_o_tp;
    assign o_out.entry_count        = r_o_count;

    wret_mem #(
        .AW (AW),
        .DW (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    wret_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.random_value),
        .i_divisor  (r_tot_pen),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("entry memory read and written in the same cycle");

    a_empty_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_tot_cost == '0 && r_tot_pen == '0))
        else $error("empty table with non-zero totals");

    a_evict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.evicted) |-> (o_out.status == ST_DONE))
        else $error("eviction reported with a failure status");

    a_out_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_OUT))
        else $error("result produced outside the output state");
`endif
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted random eviction tree testbench
// Drives add, remove, evict and unused-code items with random gaps and stalls,
// predicts each result with a behavioural sum-tree table, and compares the whole result item.
// ----------------------------------------------------------------------------
module tb_top;
    import wret_pkg::*;

    localparam int NSLOT = DEF_MAX_ENTRIES;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
        logic [COST_W-1:0]  pen;
        logic [RND_W-1:0]   rnd;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                evicted;
        logic [KEY_W-1:0]    ekey;
        logic [SUM_W-1:0]    tcost;
        logic [SUM_W-1:0]    tpen;
        logic [COUNT_W-1:0]  count;
    } res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    wret_in_if  in_ch();
    wret_out_if out_ch();
    wret_cfg_if cfg_ch();

    weighted_random_eviction_tree_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Table mirror
    logic [KEY_W-1:0]  t_key [NSLOT];
    logic [COST_W-1:0] t_oc  [NSLOT];
    logic [COST_W-1:0] t_op  [NSLOT];
    logic [SUM_W-1:0]  t_cc  [NSLOT];
    logic [SUM_W-1:0]  t_cp  [NSLOT];
    int unsigned       held;
    logic [SUM_W-1:0]  limit_reg;

    op_t  pending_ops[$];
    res_t expected_results[$];
    int   mismatches;
    bit   sender_hold;
    longint cycles;

    function automatic logic [SUM_W-1:0] pen_sum(int unsigned i);
        if (i >= held) return '0;
        return SUM_W'(t_op[i]) + t_cp[i];
    endfunction

    function automatic logic [SUM_W-1:0] cost_sum(int unsigned i);
        if (i >= held) return '0;
        return SUM_W'(t_oc[i]) + t_cc[i];
    endfunction

    function automatic void lift_sums(int unsigned i, logic [SUM_W-1:0] dc,
                                      logic [SUM_W-1:0] dp);
        while (i > 0) begin
            i = (i - 1) / 2;
            t_cc[i] = t_cc[i] + dc;
            t_cp[i] = t_cp[i] + dp;
        end
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] k);
        for (int i = 0; i < held; i++)
            if (t_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void drop_slot(int unsigned idx);
        int unsigned last;
        logic [SUM_W-1:0] lc, lp;
        last = held - 1;
        lc = SUM_W'(t_oc[last]);
        lp = SUM_W'(t_op[last]);
        held = last;
        lift_sums(last, -lc, -lp);
        if (idx < last) begin
            lift_sums(idx, lc - SUM_W'(t_oc[idx]), lp - SUM_W'(t_op[idx]));
            t_key[idx] = t_key[last];
            t_oc[idx] = t_oc[last];
            t_op[idx] = t_op[last];
        end
    endfunction

    function automatic int unsigned pick_weighted(logic [SUM_W-1:0] w);
        int unsigned i, l;
        logic [SUM_W:0] left, here;
        i = 0;
        while (i < held) begin
            l = 2 * i + 1;
            left = pen_sum(l);
            here = left + t_op[i];
            if (w < left) i = l;
            else if (w < here) return i;
            else begin
                w = w - SUM_W'(here);
                i = l + 1;
            end
        end
        return held - 1;
    endfunction

    function automatic res_t predict_table_op(op_t op);
        res_t r;
        int s;
        logic [SUM_W-1:0] tot;
        r = '0;
        case (op.func)
            FUNC_ADD: begin
                s = find_slot(op.key);
                if (s >= 0) r.status = ST_DUP;
                else if (held >= NSLOT) r.status = ST_FULL;
                else begin
                    t_key[held] = op.key;
                    t_oc[held] = op.cost;
                    t_op[held] = op.pen;
                    t_cc[held] = '0;
                    t_cp[held] = '0;
                    lift_sums(held, SUM_W'(op.cost), SUM_W'(op.pen));
                    held++;
                end
            end
            FUNC_REMOVE: begin
                s = find_slot(op.key);
                if (s >= 0) drop_slot(s);
                else r.status = ST_NOTFOUND;
            end
            FUNC_EVICT: begin
                tot = pen_sum(0);
                if (tot <= limit_reg || held == 0) r.status = ST_UNDER;
                else begin
                    s = pick_weighted(SUM_W'(op.rnd % tot));
                    r.evicted = 1'b1;
                    r.ekey = t_key[s];
                    drop_slot(s);
                end
            end
            default: r.status = ST_DONE;
        endcase
        r.tcost = cost_sum(0);
        r.tpen = pen_sum(0);
        r.count = COUNT_W'(held);
        return r;
    endfunction

    // Driver
    int send_gap;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = '0;
        in_ch.entry_key = '0;
        in_ch.entry_cost = '0;
        in_ch.entry_penalty_cost = '0;
        in_ch.random_value = '0;
        send_gap = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.insert(expected_results.size(),
                    predict_table_op(op_t'({in_ch.func,
                    in_ch.entry_key, in_ch.entry_cost, in_ch.entry_penalty_cost,
                    in_ch.random_value})));
                send_gap = $urandom_range(0, 3);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (pending_ops.size() > 0 && !sender_hold) begin
                    op_t op;
                    op = pending_ops.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.func <= op.func;
                    in_ch.entry_key <= op.key;
                    in_ch.entry_cost <= op.cost;
                    in_ch.entry_penalty_cost <= op.pen;
                    in_ch.random_value <= op.rnd;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    int stall;
    initial begin
        out_ch.ready = 1'b0;
        stall = 0;
        mismatches = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                res_t got, want;
                got = {out_ch.status, out_ch.evicted, out_ch.evicted_key,
                       out_ch.total_cost, out_ch.total_penalty_cost, out_ch.entry_count};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
                stall = $urandom_range(0, 3);
            end
            if (stall > 0) begin
                stall <= stall - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                            logic [COST_W-1:0] c, logic [COST_W-1:0] p,
                            logic [RND_W-1:0] r);
        pending_ops.insert(pending_ops.size(), op_t'({f, k, c, p, r}));
    endtask

    task automatic wait_drained();
        while (pending_ops.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [SUM_W-1:0] v);
        cfg_ch.data <= v;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        limit_reg = v;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    logic [KEY_W-1:0] live_keys[$];

    // Random phase: mostly well-formed add/remove/evict on a small key pool.
    task automatic random_phase(int n, int pool);
        logic [KEY_W-1:0] k;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            k = (live_keys.size() > 0 && $urandom_range(0, 1))
                ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                : (($urandom_range(0, 3) == 0) ? rand64() : KEY_W'($urandom_range(1, pool)));
            if (sel < 50) begin
                live_keys.insert(live_keys.size(), k);
                queue_op(FUNC_ADD, k, COST_W'($urandom()), COST_W'($urandom()), rand64());
            end else if (sel < 70) begin
                queue_op(FUNC_REMOVE, k, COST_W'($urandom()), COST_W'($urandom()), rand64());
            end else if (sel < 97) begin
                queue_op(FUNC_EVICT, rand64(), COST_W'($urandom()), COST_W'($urandom()),
                         rand64());
            end else begin
                queue_op(FUNC_UNUSED, rand64(), COST_W'($urandom()), COST_W'($urandom()),
                         rand64());
            end
        end
    endtask

    initial begin
        held = 0;
        limit_reg = LIMIT_RESET;
        cycles = 0;
        sender_hold = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every operation and the duplicate, not-found and under-limit cases.
        queue_op(FUNC_EVICT, 0, 0, 0, 0);
        queue_op(FUNC_REMOVE, 64'h5, 0, 0, 0);
        queue_op(FUNC_ADD, '1, '1, '1, '1);
        queue_op(FUNC_ADD, '1, 1, 1, 0);
        queue_op(FUNC_ADD, 64'h0, 0, 0, 0);
        queue_op(FUNC_ADD, 64'h8000_0000_0000_0001, 24'h800000, 24'h7FFFFF, 0);
        for (int i = 0; i < 10; i++)
            queue_op(FUNC_ADD, 64'(100 + i), 24'(i * 1000), 24'h0FFFFF + 24'(i), 0);
        queue_op(FUNC_UNUSED, '1, '1, '1, '1);
        queue_op(FUNC_EVICT, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_op(FUNC_REMOVE, 64'h0, 0, 0, 0);
        queue_op(FUNC_REMOVE, 64'(100), 0, 0, 0);
        queue_op(FUNC_REMOVE, 64'(109), 0, 0, 0);
        queue_op(FUNC_REMOVE, 64'(109), 0, 0, 0);
        wait_drained();

        write_limit('0);
        queue_op(FUNC_EVICT, 0, 0, 0, 0);
        queue_op(FUNC_EVICT, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_op(FUNC_EVICT, 0, 0, 0, 64'h1234_5678_9ABC_DEF0);
        wait_drained();

        // Low limit: evictions frequent.
        write_limit(40'd20000000);
        random_phase(180, 40);
        // Let part of the batch go out, then pause the sender until every
        // result has come.
        while (pending_ops.size() > 120) @(posedge i_clk);
        sender_hold = 1'b1;
        while (expected_results.size() > 0 || in_ch.valid) @(posedge i_clk);
        sender_hold = 1'b0;
        random_phase(60, 40);
        wait_drained();

        write_limit('1);
        random_phase(60, 30);
        wait_drained();

        write_limit(LIMIT_RESET);
        random_phase(100, 60);
        wait_drained();

        write_limit('0);
        random_phase(100, 20);
        wait_drained();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/wret_pkg.sv
hdl/wret_if.sv
hdl/wret_mem.sv
hdl/wret_div.sv
hdl/weighted_random_eviction_tree_unit.sv
test/tb_top.sv
